>>> design/ele_pkg.sv
// shared types, constants and message tables for the line editor
package ele_pkg;

  // line buffer size and the number of leading characters kept
  localparam int LINE_BUF_SIZE = 128;
  localparam int HEAD_LEN      = 5;
  localparam int CNT_W         = $clog2(LINE_BUF_SIZE);
  localparam int HEAD_IDX_W    = $clog2(HEAD_LEN);

  // job queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // byte index within one job's message
  localparam int MIDX_W = 4;

  // control characters
  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_DEL = 8'h7F;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_NUL = 8'h00;

  // operation codes of the input channel
  localparam logic OP_BYTE     = 1'b0;
  localparam logic OP_OVERFLOW = 1'b1;

  // message texts
  localparam logic [7:0] TXT_PING   [4] = '{8'h70, 8'h69, 8'h6E, 8'h67};
  localparam logic [7:0] TXT_PONG   [8] = '{8'h3C, 8'h20, 8'h50, 8'h4F,
                                            8'h4E, 8'h47, 8'h0D, 8'h0A};
  localparam logic [7:0] TXT_NACK   [8] = '{8'h3C, 8'h20, 8'h4E, 8'h41,
                                            8'h43, 8'h4B, 8'h0D, 8'h0A};
  localparam logic [7:0] TXT_PROMPT [3] = '{8'h3E, 8'h3E, 8'h20};
  localparam logic [7:0] TXT_ERASE  [3] = '{8'h08, 8'h20, 8'h08};
  localparam logic [7:0] TXT_CRLF   [2] = '{8'h0D, 8'h0A};

  // kinds of work handed from front to back
  typedef enum logic [2:0] {
    JOB_ECHO,
    JOB_ERASE,
    JOB_LINE_BARE,
    JOB_LINE_PONG,
    JOB_LINE_NACK
  } job_kind_t;

  typedef struct packed {
    job_kind_t  kind;
    logic [7:0] data;
  } job_t;

  // queue status seen by front and back
  typedef struct packed {
    logic full;
    logic not_empty;
  } queue_stat_t;

  // index of the final byte of a job's message
  function automatic logic [MIDX_W-1:0] msg_last(input job_kind_t kind);
    logic [MIDX_W-1:0] res;
    unique case (kind)
      JOB_ECHO:                     res = MIDX_W'(0);
      JOB_ERASE:                    res = MIDX_W'(2);
      JOB_LINE_BARE:                res = MIDX_W'(4);
      JOB_LINE_PONG, JOB_LINE_NACK: res = MIDX_W'(12);
      default:                      res = MIDX_W'(0);
    endcase
    return res;
  endfunction

  // one byte of a job's message
  function automatic logic [7:0] msg_byte(input job_kind_t kind,
                                          input logic [MIDX_W-1:0] idx,
                                          input logic [7:0] data);
    logic [7:0]        res;
    logic [MIDX_W-1:0] rel;
    res = CH_NUL;
    rel = '0;
    unique case (kind)
      JOB_ECHO:  res = data;
      JOB_ERASE: res = TXT_ERASE[idx[1:0]];
      JOB_LINE_BARE: begin
        if (idx < MIDX_W'(2)) begin
          res = TXT_CRLF[idx[0]];
        end else begin
          rel = idx - MIDX_W'(2);
          res = TXT_PROMPT[rel[1:0]];
        end
      end
      JOB_LINE_PONG, JOB_LINE_NACK: begin
        if (idx < MIDX_W'(2)) begin
          res = TXT_CRLF[idx[0]];
        end else if (idx < MIDX_W'(10)) begin
          rel = idx - MIDX_W'(2);
          res = (kind == JOB_LINE_PONG) ? TXT_PONG[rel[2:0]] : TXT_NACK[rel[2:0]];
        end else begin
          rel = idx - MIDX_W'(10);
          res = TXT_PROMPT[rel[1:0]];
        end
      end
      default: res = CH_NUL;
    endcase
    return res;
  endfunction

endpackage

>>> design/ele_front.sv
// front end: takes input transfers, keeps the line state and queues jobs
module ele_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic          in_operation,
  input  logic [7:0]    in_rx_byte,
  input  ele_pkg::queue_stat_t q_stat,
  output logic          push,
  output ele_pkg::job_t push_job
);
  import ele_pkg::*;

  logic [CNT_W-1:0] count_r, count_nxt;
  logic [7:0]       head_r [HEAD_LEN];
  logic             accept;
  logic             is_ping;
  logic             head_wr;

  // hold off while the queue has no room
  assign in_stall = q_stat.full;
  assign accept   = in_valid && !in_stall;

  // line reads as the ping command, a NUL fifth character ends it early
  always_comb begin
    is_ping = (count_r >= CNT_W'(4)) &&
              (head_r[0] == TXT_PING[0]) && (head_r[1] == TXT_PING[1]) &&
              (head_r[2] == TXT_PING[2]) && (head_r[3] == TXT_PING[3]) &&
              ((count_r == CNT_W'(4)) || (head_r[4] == CH_NUL));
  end

  // classify the item and work out the new line length
  always_comb begin
    count_nxt     = count_r;
    push          = 1'b0;
    push_job.kind = JOB_ECHO;
    push_job.data = in_rx_byte;
    head_wr       = 1'b0;
    if (accept) begin
      if (in_operation == OP_OVERFLOW) begin
        count_nxt = '0;
      end else if (in_rx_byte == CH_CR || in_rx_byte == CH_LF) begin
        push = 1'b1;
        if (count_r == '0) begin
          push_job.kind = JOB_LINE_BARE;
        end else if (is_ping) begin
          push_job.kind = JOB_LINE_PONG;
        end else begin
          push_job.kind = JOB_LINE_NACK;
        end
        count_nxt = '0;
      end else if (in_rx_byte == CH_BS || in_rx_byte == CH_DEL) begin
        if (count_r != '0) begin
          push          = 1'b1;
          push_job.kind = JOB_ERASE;
          count_nxt     = count_r - CNT_W'(1);
        end
      end else if (count_r < CNT_W'(LINE_BUF_SIZE - 1)) begin
        push      = 1'b1;
        head_wr   = (count_r < CNT_W'(HEAD_LEN));
        count_nxt = count_r + CNT_W'(1);
      end
    end
  end

  // line length
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // leading characters of the line
  always_ff @(posedge clk) begin
    if (head_wr) begin
      head_r[count_r[HEAD_IDX_W-1:0]] <= in_rx_byte;
    end
  end

endmodule

>>> design/ele_queue.sv
// short job queue between the front end and the transmit sequencer
module ele_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  ele_pkg::job_t         push_job,
  input  logic                  pop,
  output ele_pkg::job_t         head_job,
  output ele_pkg::queue_stat_t  q_stat
);
  import ele_pkg::*;

  job_t              slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]   fill_r;

  assign head_job         = slot_r[rd_ptr_r];
  assign q_stat.full      = (fill_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign q_stat.not_empty = (fill_r != '0);

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      if (push && !pop) begin
        fill_r <= fill_r + (QPTR_W+1)'(1);
      end else if (pop && !push) begin
        fill_r <= fill_r - (QPTR_W+1)'(1);
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

>>> design/ele_back.sv
// transmit sequencer: spells out each job's bytes into the output register
module ele_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ele_pkg::job_t         head_job,
  input  ele_pkg::queue_stat_t  q_stat,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [7:0]            out_tx_byte,
  output logic                  out_last_byte
);
  import ele_pkg::*;

  logic              busy_r, busy_nxt;
  job_t              job_r, job_nxt;
  logic [MIDX_W-1:0] idx_r, idx_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [7:0]        out_tx_byte_r, out_tx_byte_nxt;
  logic              out_last_byte_r, out_last_byte_nxt;

  job_t              cur_job;
  logic              cur_valid;
  logic [MIDX_W-1:0] cur_idx;
  logic              out_free;
  logic              cur_last;

  // current job comes from the holding register or straight off the queue
  assign cur_job   = busy_r ? job_r : head_job;
  assign cur_valid = busy_r || q_stat.not_empty;
  assign cur_idx   = busy_r ? idx_r : '0;
  assign out_free  = !out_valid_r || !out_stall;
  assign cur_last  = (cur_idx == msg_last(cur_job.kind));

  // one byte per cycle while the output register has room
  always_comb begin
    busy_nxt          = busy_r;
    job_nxt           = job_r;
    idx_nxt           = idx_r;
    pop               = 1'b0;
    out_valid_nxt     = out_valid_r && out_stall;
    out_tx_byte_nxt   = out_tx_byte_r;
    out_last_byte_nxt = out_last_byte_r;
    if (cur_valid && out_free) begin
      out_valid_nxt     = 1'b1;
      out_tx_byte_nxt   = msg_byte(cur_job.kind, cur_idx, cur_job.data);
      out_last_byte_nxt = cur_last;
      pop               = !busy_r;
      if (cur_last) begin
        busy_nxt = 1'b0;
      end else begin
        busy_nxt = 1'b1;
        job_nxt  = cur_job;
        idx_nxt  = cur_idx + MIDX_W'(1);
      end
    end
  end

  // sequencer state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
    job_r           <= job_nxt;
    idx_r           <= idx_nxt;
    out_tx_byte_r   <= out_tx_byte_nxt;
    out_last_byte_r <= out_last_byte_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_tx_byte   = out_tx_byte_r;
  assign out_last_byte = out_last_byte_r;

endmodule

>>> design/echo_line_editor.sv
// top level of the terminal line editor with echo
//
//  channel | direction | handshake           | payload
//  in_     | input     | in_valid / in_stall | in_operation, in_rx_byte
//  out_    | output    | out_valid/out_stall | out_tx_byte, out_last_byte
//
// an input transfer is classified in its cycle and queued as a job;
// the sequencer sends one byte per cycle while the output is not stalled: 1 for an echo, 3 for an erase,
// 5 for an empty line end and 13 for a line end with a reply.
// input is taken every cycle while the four-entry job queue has room.
// reset (synchronous, active low) empties the line and the queue.
// a stalled output holds its byte and the sequencer waits behind it.
module echo_line_editor (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_operation,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_tx_byte,
  output logic       out_last_byte
);
  import ele_pkg::*;

  logic        push;
  job_t        push_job;
  logic        pop;
  job_t        head_job;
  queue_stat_t q_stat;

  // classification and line state
  ele_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_operation (in_operation),
    .in_rx_byte   (in_rx_byte),
    .q_stat       (q_stat),
    .push         (push),
    .push_job     (push_job)
  );

  // job queue
  ele_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .q_stat   (q_stat)
  );

  // byte sequencer
  ele_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head_job      (head_job),
    .q_stat        (q_stat),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_tx_byte   (out_tx_byte),
    .out_last_byte (out_last_byte)
  );

endmodule

>>> design/ele_checker.sv
// port-level checks for the line editor, bound to the top level
module ele_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       in_operation,
  input logic [7:0] in_rx_byte,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_tx_byte,
  input logic       out_last_byte
);
  import ele_pkg::*;

  logic out_xfer;
  assign out_xfer = out_valid && !out_stall;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_tx_byte) &&
                               $stable(out_last_byte))
    else $error("stalled result changed");

  // nothing pending straight after reset
  a_reset_quiet: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid && !in_stall)
    else $error("block not idle after reset");

  // a message runs without gaps until its final byte
  a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_xfer && !out_last_byte |=> out_valid)
    else $error("gap inside a message");

  // a carriage return inside a message is always followed by a line feed
  a_crlf: assert property (@(posedge clk) disable iff (!rst_n)
    out_xfer && !out_last_byte && out_tx_byte == CH_CR |=> out_tx_byte == CH_LF)
    else $error("carriage return not followed by line feed");

endmodule

bind echo_line_editor ele_checker u_ele_checker (.*);

>>> dv/ele_tb_pkg.sv
// scoreboard class for the line editor testbench: expected result bytes and their checks
`timescale 1ns / 1ps

package ele_tb_pkg;
  import ele_pkg::*;

  // one transmitted byte as expected on the result channel
  typedef struct packed {
    logic [7:0] tx;
    logic       is_last;
  } tx_beat_t;

  class echo_scoreboard;
    logic [CNT_W-1:0] line_len;
    logic [7:0]       head [HEAD_LEN];
    tx_beat_t         tx_due [$];
    int errors;
    int inputs;
    int beats;
    int pongs;
    int nacks;
    int erases;
    int drops;

    function new();
      line_len = '0;
      errors   = 0;
      inputs   = 0;
      beats    = 0;
      pongs    = 0;
      nacks    = 0;
      erases   = 0;
      drops    = 0;
    endfunction

    task report(string what);
      errors++;
      $display("[%0t] mismatch: %s", $time, what);
    endtask

    function void push_byte(logic [7:0] b);
      tx_due.push_back('{b, 1'b0});
    endfunction

    function void push_text(string s);
      for (int i = 0; i < s.len(); i++) push_byte(s[i]);
    endfunction

    // C string rule: a nul in the fifth place ends the line early
    function bit reads_ping();
      string ping_txt;
      ping_txt = "ping";
      if (line_len < CNT_W'(4)) return 1'b0;
      for (int i = 0; i < 4; i++) begin
        if (head[i] != ping_txt[i]) return 1'b0;
      end
      return (line_len == CNT_W'(4)) || (head[4] == CH_NUL);
    endfunction

    // work out the bytes sent back for one accepted input transfer
    function void note_input(logic op, logic [7:0] b);
      int start;
      start = tx_due.size();
      inputs++;
      if (op == OP_OVERFLOW) begin
        line_len = '0;
        return;
      end
      if (b == CH_CR || b == CH_LF) begin
        push_byte(CH_CR);
        push_byte(CH_LF);
        if (line_len != '0) begin
          if (reads_ping()) begin
            push_text("< PONG");
            pongs++;
          end else begin
            push_text("< NACK");
            nacks++;
          end
          push_byte(CH_CR);
          push_byte(CH_LF);
        end
        line_len = '0;
        push_text(">> ");
      end else if (b == CH_BS || b == CH_DEL) begin
        if (line_len != '0) begin
          line_len = line_len - CNT_W'(1);
          push_byte(CH_BS);
          push_byte(CH_SP);
          push_byte(CH_BS);
          erases++;
        end
      end else if (line_len < CNT_W'(LINE_BUF_SIZE - 1)) begin
        if (line_len < CNT_W'(HEAD_LEN)) head[line_len[HEAD_IDX_W-1:0]] = b;
        line_len = line_len + CNT_W'(1);
        push_byte(b);
      end else begin
        drops++;
      end
      if (tx_due.size() > start) tx_due[tx_due.size() - 1].is_last = 1'b1;
    endfunction

    // compare one result transfer with the oldest expected byte
    task check_tx(logic [7:0] tx, logic is_last);
      tx_beat_t want;
      beats++;
      if (tx_due.size() == 0) begin
        report($sformatf("unexpected byte %02h last %0b", tx, is_last));
        return;
      end
      want = tx_due.pop_front();
      if (tx !== want.tx)
        report($sformatf("tx_byte %02h, wanted %02h", tx, want.tx));
      if (is_last !== want.is_last)
        report($sformatf("last_byte %0b, wanted %0b (byte %02h)", is_last, want.is_last, tx));
    endtask
  endclass

endpackage

>>> dv/testbench.sv
// top of the line editor testbench: clock, reset, drivers, receiver and watchdog
`timescale 1ns / 1ps

module testbench;
  import ele_pkg::*;
  import ele_tb_pkg::*;

  localparam int HOLD_CYCLES    = 60;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 20;
  localparam int RANDOM_ITEMS   = 190;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic       in_operation;
  logic [7:0] in_rx_byte;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_tx_byte;
  logic       out_last_byte;

  echo_scoreboard sb;
  bit calm_in;
  bit calm_out;
  bit hold_req;
  int idle_cycles;

  echo_line_editor dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_operation (in_operation),
    .in_rx_byte   (in_rx_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_tx_byte  (out_tx_byte),
    .out_last_byte(out_last_byte)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // offer one item after a random gap and hold it until the transfer
  task send_item(input logic op, input logic [7:0] b);
    int gap;
    bit taken;
    gap = calm_in ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_rx_byte   <= b;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      if (in_stall === 1'b0) begin
        taken = 1'b1;
        sb.note_input(op, b);
      end
      @(posedge clk);
    end
  endtask

  task send_text(string s);
    for (int i = 0; i < s.len(); i++) send_item(OP_BYTE, s[i]);
  endtask

  // a byte that is stored and echoed, never a line end or an erase character
  function logic [7:0] plain_char();
    logic [7:0] r;
    do begin
      r = 8'($urandom_range(0, 255));
    end while (r == CH_BS || r == CH_DEL || r == CH_CR || r == CH_LF);
    return r;
  endfunction

  function logic [7:0] line_end();
    return $urandom_range(0, 1) ? CH_CR : CH_LF;
  endfunction

  // sender pause until every expected byte has come back
  task wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.tx_due.size() != 0) @(posedge clk);
  endtask

  // lines at or near "ping", with mutations and nul-led tails
  task ping_line();
    string s;
    int tail;
    s = "ping";
    if ($urandom_range(0, 2) == 0) s[$urandom_range(0, 3)] = plain_char();
    send_text(s);
    tail = $urandom_range(0, 3);
    for (int i = 0; i < tail; i++) begin
      if (i == 0 && $urandom_range(0, 2) == 0) send_item(OP_BYTE, CH_NUL);
      else send_item(OP_BYTE, plain_char());
    end
    if ($urandom_range(0, 4) == 0) send_item(OP_BYTE, $urandom_range(0, 1) ? CH_BS : CH_DEL);
    send_item(OP_BYTE, line_end());
  endtask

  // short lines of any bytes, with erases and mixed endings
  task rough_line();
    int len;
    int sel;
    len = $urandom_range(0, 8);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 4) == 0) send_item(OP_BYTE, $urandom_range(0, 1) ? CH_BS : CH_DEL);
      else send_item(OP_BYTE, 8'($urandom_range(0, 255)));
    end
    sel = $urandom_range(0, 4);
    if (sel <= 2) send_item(OP_BYTE, line_end());
    else if (sel == 3) send_item(OP_OVERFLOW, 8'($urandom_range(0, 255)));
  endtask

  task noise();
    int n;
    n = $urandom_range(1, 4);
    for (int i = 0; i < n; i++)
      send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
  endtask

  // fill the line past its limit, erase one, refill and overrun again
  task long_line();
    wait_drained();
    for (int i = 0; i < LINE_BUF_SIZE + 2; i++) send_item(OP_BYTE, plain_char());
    send_item(OP_BYTE, CH_DEL);
    send_item(OP_BYTE, plain_char());
    send_item(OP_BYTE, plain_char());
    send_item(OP_BYTE, CH_CR);
  endtask

  // stimulus
  initial begin
    int base;
    int k;
    bit long_done;
    sb = new();
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_operation <= OP_BYTE;
    in_rx_byte   <= 8'h00;
    calm_in   = 1'b0;
    calm_out  = 1'b0;
    hold_req  = 1'b0;
    long_done = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty line end, erase on empty line, overflow, ping forms
    send_item(OP_BYTE, CH_CR);
    send_item(OP_BYTE, CH_BS);
    send_item(OP_BYTE, CH_DEL);
    send_item(OP_OVERFLOW, 8'hFF);
    send_text("ping");
    send_item(OP_BYTE, CH_CR);
    send_text("ping");
    send_item(OP_BYTE, CH_NUL);
    send_item(OP_BYTE, 8'hFF);
    send_item(OP_BYTE, CH_LF);
    send_item(OP_BYTE, 8'h78);
    send_item(OP_BYTE, CH_DEL);
    send_item(OP_BYTE, 8'hFF);
    send_item(OP_BYTE, CH_CR);
    send_text("ab");
    send_item(OP_OVERFLOW, 8'h00);
    send_item(OP_BYTE, CH_LF);

    // random lines; the receiver starts with a long hold-off
    hold_req = 1'b1;
    base = sb.inputs;
    while (sb.inputs - base < RANDOM_ITEMS) begin
      if (!long_done && sb.inputs - base > RANDOM_ITEMS / 3) begin
        long_line();
        long_done = 1'b1;
      end
      calm_in = ($urandom_range(0, 3) == 0);
      k = $urandom_range(0, 9);
      if (k < 4) ping_line();
      else if (k < 9) rough_line();
      else noise();
    end
    calm_in = 1'b0;

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.tx_due.size() != 0)
      sb.report($sformatf("%0d expected bytes never sent", sb.tx_due.size()));
    $display("covered %0d input transfers and %0d result transfers, including a full line",
             sb.inputs, sb.beats);
    $display("replies: %0d pong, %0d nack; %0d erases, %0d bytes dropped on a full line",
             sb.pongs, sb.nacks, sb.erases, sb.drops);
    if (sb.errors == 0) begin
      $display("echo_line_editor regression: pass");
    end else begin
      $display("echo_line_editor regression: fail");
    end
    $finish;
  end

  // receiver: random stalls per byte, calm stretches and one long hold-off
  initial begin
    logic [7:0] got_tx;
    logic       got_last;
    int n;
    bit fire;
    out_stall <= 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (hold_req) begin
        n = HOLD_CYCLES;
        hold_req = 1'b0;
      end else begin
        n = calm_out ? 0 : $urandom_range(0, 3);
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      fire = 1'b0;
      while (!fire) begin
        @(negedge clk);
        if (out_valid === 1'b1) begin
          fire     = 1'b1;
          got_tx   = out_tx_byte;
          got_last = out_last_byte;
        end
        @(posedge clk);
      end
      sb.check_tx(got_tx, got_last);
      if ($urandom_range(0, 31) == 0) calm_out = !calm_out;
    end
  end

  // watchdog on cycles with no transfer on either channel
  initial begin
    idle_cycles = 0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      @(negedge clk);
      if ((in_valid === 1'b1 && in_stall === 1'b0) || (out_valid === 1'b1 && out_stall === 1'b0))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no transfer for %0d cycles", idle_cycles);
        $display("echo_line_editor regression: fail");
        $finish;
      end
    end
  end

endmodule

>>> files.f
design/ele_pkg.sv
design/ele_front.sv
design/ele_queue.sv
design/ele_back.sv
design/echo_line_editor.sv
design/ele_checker.sv
dv/ele_tb_pkg.sv
dv/testbench.sv
